// ===== rtl/dfr_pkg.sv =====
package dfr_pkg;

	// Header bytes compared at most; a larger header_length setting saturates here.
	localparam int MAX_HEADER_BYTES = 4;
	// Fixed bytes after the header: total length, version, type, command, data length, CRC.
	localparam int BASE_EXTRA = 10;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Depth of the result queue. It must be a power of two and at least two.
	localparam int OUT_DEPTH = 4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [15:0] HDLEN_RESET = 16'd1024;
	localparam logic [2:0] HLEN_RESET = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_PATTERN = 2'd0,
		REG_HEADER_LENGTH = 2'd1,
		REG_MAX_FRAME_LENGTH = 2'd2
	} cfg_reg_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ST_BAD_CRC = 3'd4;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Byte offsets of the fixed fields, counted from the end of the header.
	localparam logic [2:0] FLD_LEN_HI = 3'd0;
	localparam logic [2:0] FLD_LEN_LO = 3'd1;
	localparam logic [2:0] FLD_VER_HI = 3'd2;
	localparam logic [2:0] FLD_VER_LO = 3'd3;
	localparam logic [2:0] FLD_TYPE = 3'd4;
	localparam logic [2:0] FLD_CMD = 3'd5;
	localparam logic [2:0] FLD_DLEN_HI = 3'd6;
	localparam logic [2:0] FLD_DLEN_LO = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic [7:0] payload_byte;
		logic [15:0] payload_index;
		logic [2:0] status_code;
		logic [15:0] frame_length;
		logic [15:0] protocol_version;
		logic [7:0] packet_type;
		logic [7:0] command_code;
		logic [15:0] payload_length;
		logic [15:0] received_check;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] header_pattern;
		logic [2:0] header_length;
		logic [15:0] max_frame_length;
	} cfg_t;

	// Results of one byte: an optional payload result, then an optional status result.
	typedef struct packed {
		logic pay_vld;
		out_item_t pay;
		logic st_vld;
		out_item_t st;
	} res_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/frame_deframer_crc16_check_core.sv =====
// Channel   Direction  Handshake              Payload
// in        inbound    in_valid / in_stall    in_data (rx_byte, end_of_buffer)
// out       outbound   out_valid / out_stall  out_data (payload or status result)
// cfg       inbound    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A byte is held in the input register
// and parsed there; its results are written into the result queue, which offers them.
// A byte yields at most two results; they enter a four-entry result queue, and the input
// register holds (in_stall) while fewer than two queue entries are free.
// Reset restores the default configuration and clears the frame state; no clearing pass.
// Stalls on the output side reach the input only through the queue fill level.
module frame_deframer_crc16_check_core import dfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	in_item_t item_s1;
	logic valid_s1;
	logic room, take;
	res_t res;

	// Configuration registers. Writes are always accepted; an unknown index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_pattern <= '0;
			cfg_q.header_length <= HLEN_RESET;
			cfg_q.max_frame_length <= HDLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER_PATTERN: cfg_q.header_pattern <= cfg_data;
				REG_HEADER_LENGTH: cfg_q.header_length <= cfg_data[2:0];
				REG_MAX_FRAME_LENGTH: cfg_q.max_frame_length <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The byte in the input register is parsed when the result queue can absorb the two
	// results it may produce. The stall depends only on registered state.
	assign take = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Frame state, field capture, CRC and status decision for one byte.
	dfr_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.take(take),
		.item(item_s1),
		.res(res)
	);

	// Result queue; a final payload byte pushes its payload result and then the status.
	dfr_out_fifo u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// ===== rtl/dfr_parse.sv =====
module dfr_parse import dfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic take,
	input  in_item_t item,
	output res_t res
);

	logic [15:0] pos_q, crc_q, len_q, ver_q, dlen_q, rcrc_q;
	logic [7:0] typ_q, cmd_q;
	logic [2:0] ferr_q;

	logic [15:0] pos_d, crc_d, len_d, ver_d, dlen_d, rcrc_d;
	logic [7:0] typ_d, cmd_d;
	logic [2:0] ferr_d;

	logic [3:0] hlen4, hdr_n;
	logic [4:0] base;
	logic [16:0] base17, dlen_lo_sum, end_sum;
	logic [7:0] b, exp_byte;
	logic [15:0] rel, off;
	logic in_crc, pay_hit;
	logic [2:0] status;

	assign b = item.rx_byte;
	assign hlen4 = {1'b0, cfg.header_length};
	assign hdr_n = (hlen4 > 4'(MAX_HEADER_BYTES)) ? 4'(MAX_HEADER_BYTES) : hlen4;
	assign base = 5'(hdr_n) + 5'(BASE_EXTRA);
	assign base17 = 17'(base);
	assign rel = pos_q - 16'(hdr_n);
	assign off = rel - 16'd8;
	// Header bytes past the fourth are expected to be zero.
	assign exp_byte = (pos_q[15:2] == 14'd0) ?
		cfg.header_pattern[{pos_q[1:0], 3'b000} +: 8] : 8'h00;
	assign dlen_lo_sum = base17 + 17'({dlen_q[15:8], b});

	always_comb begin
		pos_d = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
		len_d = len_q;
		ver_d = ver_q;
		typ_d = typ_q;
		cmd_d = cmd_q;
		dlen_d = dlen_q;
		rcrc_d = rcrc_q;
		ferr_d = ferr_q;
		in_crc = 1'b0;
		pay_hit = 1'b0;
		if (pos_q < 16'(hdr_n)) begin
			in_crc = 1'b1;
			if (b != exp_byte && ferr_q == ST_OK) begin
				ferr_d = ST_BAD_HEADER;
			end
		end else if (rel[15:3] == 13'd0) begin
			in_crc = 1'b1;
			case (rel[2:0])
				FLD_LEN_HI: len_d = {b, len_q[7:0]};
				FLD_LEN_LO: len_d = {len_q[15:8], b};
				FLD_VER_HI: ver_d = {b, ver_q[7:0]};
				FLD_VER_LO: ver_d = {ver_q[15:8], b};
				FLD_TYPE: typ_d = b;
				FLD_CMD: cmd_d = b;
				FLD_DLEN_HI: dlen_d = {b, dlen_q[7:0]};
				FLD_DLEN_LO: begin
					dlen_d = {dlen_q[15:8], b};
					if (ferr_q == ST_OK && (len_q != dlen_lo_sum[15:0] ||
						dlen_lo_sum > 17'(cfg.max_frame_length))) begin
						ferr_d = ST_BAD_LENGTH;
					end
				end
				default: ;
			endcase
		end else if (ferr_q == ST_OK) begin
			// Past the fixed fields: payload, then the two CRC bytes, then ignored bytes.
			if (off < dlen_q) begin
				pay_hit = 1'b1;
				in_crc = 1'b1;
			end else if (off == dlen_q) begin
				rcrc_d = {b, rcrc_q[7:0]};
			end else if ({1'b0, off} == 17'(dlen_q) + 17'd1) begin
				rcrc_d = {rcrc_q[15:8], b};
			end
		end
		crc_d = in_crc ? crc16_byte(crc_q, b) : crc_q;
	end

	assign end_sum = base17 + 17'(dlen_d);

	always_comb begin
		if (pos_d < 16'(base)) begin
			status = ST_TOO_SHORT;
		end else if (ferr_d != ST_OK) begin
			status = ferr_d;
		end else if ({1'b0, pos_d} < end_sum) begin
			status = ST_TOO_SHORT;
		end else if (crc_d != rcrc_d) begin
			status = ST_BAD_CRC;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		res = '0;
		res.pay_vld = take && pay_hit;
		res.pay.result_kind = KIND_PAYLOAD;
		res.pay.payload_byte = b;
		res.pay.payload_index = off;
		res.st_vld = take && item.end_of_buffer;
		res.st.result_kind = KIND_STATUS;
		res.st.status_code = status;
		res.st.frame_length = len_d;
		res.st.protocol_version = ver_d;
		res.st.packet_type = typ_d;
		res.st.command_code = cmd_d;
		res.st.payload_length = dlen_d;
		res.st.received_check = rcrc_d;
		res.st.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			len_q <= '0;
			ver_q <= '0;
			typ_q <= '0;
			cmd_q <= '0;
			dlen_q <= '0;
			rcrc_q <= '0;
			ferr_q <= ST_OK;
		end else if (take) begin
			if (item.end_of_buffer) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				len_q <= '0;
				ver_q <= '0;
				typ_q <= '0;
				cmd_q <= '0;
				dlen_q <= '0;
				rcrc_q <= '0;
				ferr_q <= ST_OK;
			end else begin
				pos_q <= pos_d;
				crc_q <= crc_d;
				len_q <= len_d;
				ver_q <= ver_d;
				typ_q <= typ_d;
				cmd_q <= cmd_d;
				dlen_q <= dlen_d;
				rcrc_q <= rcrc_d;
				ferr_q <= ferr_d;
			end
		end
	end

endmodule

// ===== rtl/dfr_out_fifo.sv =====
module dfr_out_fifo import dfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  res_t res,
	output logic room,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_data
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	out_item_t mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q, wp1;
	logic [CNT_W-1:0] cnt_q;
	logic wr0, wr1, pop;
	out_item_t d0;

	// The first free slot takes the payload result if there is one, else the status.
	assign wr0 = res.pay_vld || res.st_vld;
	assign wr1 = res.pay_vld && res.st_vld;
	assign d0 = res.pay_vld ? res.pay : res.st;
	assign wp1 = wp_q + PTR_W'(1);

	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rp_q];
	assign pop = out_valid && !out_stall;
	assign room = (cnt_q <= CNT_W'(OUT_DEPTH - 2));

	always_ff @(posedge clk) begin
		for (int i = 0; i < OUT_DEPTH; i++) begin
			if (wr0 && wp_q == PTR_W'(i)) begin
				mem_q[i] <= d0;
			end else if (wr1 && wp1 == PTR_W'(i)) begin
				mem_q[i] <= res.st;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PTR_W'(wr0) + PTR_W'(wr1);
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(wr0) + CNT_W'(wr1) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/dfr_checker.sv =====
module dfr_checker import dfr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_data
);

	// A result held by the receiver stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// The input holds only while results are waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_STATUS |->
			out_data.last && out_data.payload_byte == 8'd0 &&
			out_data.payload_index == 16'd0)
		else $error("malformed status result");

	a_payload_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_PAYLOAD |->
			!out_data.last && out_data.status_code == ST_OK &&
			out_data.frame_length == 16'd0 && out_data.received_check == 16'd0)
		else $error("malformed payload result");

endmodule

bind frame_deframer_crc16_check_core dfr_checker u_dfr_checker (.*);

// ===== tb/tb_frame_deframer_crc16_check_core.sv =====
module tb_frame_deframer_crc16_check_core;
	import dfr_pkg::*;

	// Kinds of rows in the directed table. A CRC row carries the running check value
	// of the bytes sent since the last end of buffer, so the table stays readable.
	typedef enum logic [1:0] {
		ROW_LIT,
		ROW_CRC_HI,
		ROW_CRC_LO
	} row_kind_t;

	// The check tag travels with every byte. Its top bit marks a status code typed into
	// the table; the low bits hold that code. A clear top bit means the status comes from
	// the frame predictor.
	localparam logic [3:0] FROM_MODEL = 4'b0000;

	typedef struct packed {
		row_kind_t kind;
		logic [7:0] value;
		logic eob;
		logic [3:0] tag;
	} row_t;

	// Directed frames, all under the reset configuration (two zero header bytes, so the
	// base length is twelve and the largest frame is 1024 bytes).
	localparam int DIRECTED_ROWS = 26;
	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		// A good frame with the field extremes: version 0xFFFF, type 0xFF, command 0,
		// one payload byte of 0xFF.
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h0D, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'hFF, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'hFF, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'hFF, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h01, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'hFF, 1'b0, FROM_MODEL},
		'{ROW_CRC_HI, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_CRC_LO, 8'h00, 1'b1, {1'b1, ST_OK}},
		// A one-byte buffer is shorter than any frame.
		'{ROW_LIT, 8'hFF, 1'b1, {1'b1, ST_TOO_SHORT}},
		// A frame cut off inside its payload: its final byte is itself a payload byte,
		// so that payload transfer comes out ahead of the status.
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h0E, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h00, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h02, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h11, 1'b0, FROM_MODEL},
		'{ROW_LIT, 8'h22, 1'b1, {1'b1, ST_TOO_SHORT}}
	};

	localparam int PHASES = 7;
	localparam int PHASE_BYTES = 260;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic [3:0] row_check = FROM_MODEL;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Copy of the configuration as the block should hold it.
	logic [31:0] cfg_hp = 32'h0;
	logic [2:0] cfg_hl = HLEN_RESET;
	logic [15:0] cfg_mfl = HDLEN_RESET;

	// Frame state of the predictor.
	int pos = 0;
	logic [15:0] acc_crc = CRC_INIT;
	logic [15:0] got_len = '0;
	logic [15:0] got_ver = '0;
	logic [7:0] got_type = '0;
	logic [7:0] got_cmd = '0;
	logic [15:0] got_dlen = '0;
	logic [15:0] got_crc = '0;
	logic [2:0] frame_error = ST_OK;

	out_item_t expected_results[$];
	logic [7:0] buffer_bytes[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int payloads_seen = 0;
	int statuses_seen = 0;
	int status_hist [5] = '{0, 0, 0, 0, 0};
	int burst_left = 0;
	int gap_max = 4;
	logic [7:0] stall_tick = '0;
	int stall_mode = 0;

	frame_deframer_crc16_check_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// CRC-16/CCITT-FALSE, one message bit at a time from the top bit of the byte down.
	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic int header_bytes();
		return (cfg_hl > MAX_HEADER_BYTES) ? MAX_HEADER_BYTES : int'(cfg_hl);
	endfunction

	task automatic clear_frame_state();
		pos = 0;
		acc_crc = CRC_INIT;
		got_len = '0;
		got_ver = '0;
		got_type = '0;
		got_cmd = '0;
		got_dlen = '0;
		got_crc = '0;
		frame_error = ST_OK;
	endtask

	// Frame predictor: advances the parse by one accepted byte and queues the results
	// that byte should produce, payload first, then the status on the final byte.
	task automatic parse_byte(in_item_t it, logic [3:0] tag);
		int h;
		int base;
		int rel;
		int off;
		logic [7:0] b;
		logic covered;
		logic [2:0] st;
		out_item_t r;
		b = it.rx_byte;
		h = header_bytes();
		base = h + BASE_EXTRA;
		covered = 1'b0;
		if (pos < h) begin
			covered = 1'b1;
			if (b != cfg_hp[8*pos +: 8] && frame_error == ST_OK) begin
				frame_error = ST_BAD_HEADER;
			end
		end else begin
			rel = pos - h;
			if (rel < 8) begin
				covered = 1'b1;
			end
			case (rel)
				FLD_LEN_HI: got_len[15:8] = b;
				FLD_LEN_LO: got_len[7:0] = b;
				FLD_VER_HI: got_ver[15:8] = b;
				FLD_VER_LO: got_ver[7:0] = b;
				FLD_TYPE: got_type = b;
				FLD_CMD: got_cmd = b;
				FLD_DLEN_HI: got_dlen[15:8] = b;
				FLD_DLEN_LO: begin
					got_dlen[7:0] = b;
					// The total length must match exactly (modulo 16 bits) and the whole
					// frame must fit under the configured maximum.
					if (frame_error == ST_OK &&
						(got_len != 16'(base + got_dlen) || base + got_dlen > cfg_mfl)) begin
						frame_error = ST_BAD_LENGTH;
					end
				end
				default: begin
					// Once an error is recorded, nothing is forwarded and the carried
					// check value is no longer captured.
					if (frame_error == ST_OK) begin
						off = rel - 8;
						if (off < got_dlen) begin
							covered = 1'b1;
							r = '0;
							r.result_kind = KIND_PAYLOAD;
							r.payload_byte = b;
							r.payload_index = off[15:0];
							expected_results.push_back(r);
						end else if (off == got_dlen) begin
							got_crc[15:8] = b;
						end else if (off == got_dlen + 1) begin
							got_crc[7:0] = b;
						end
					end
				end
			endcase
		end
		if (covered) begin
			acc_crc = crc_step(acc_crc, b);
		end
		// The byte count sticks at its ceiling on very long buffers.
		if (pos < 65535) begin
			pos++;
		end
		if (it.end_of_buffer) begin
			if (pos < base) begin
				st = ST_TOO_SHORT;
			end else if (frame_error != ST_OK) begin
				st = frame_error;
			end else if (pos < base + got_dlen) begin
				st = ST_TOO_SHORT;
			end else if (acc_crc != got_crc) begin
				st = ST_BAD_CRC;
			end else begin
				st = ST_OK;
			end
			if (tag[3]) begin
				st = tag[2:0];
			end
			r = '0;
			r.result_kind = KIND_STATUS;
			r.status_code = st;
			r.frame_length = got_len;
			r.protocol_version = got_ver;
			r.packet_type = got_type;
			r.command_code = got_cmd;
			r.payload_length = got_dlen;
			r.received_check = got_crc;
			r.last = 1'b1;
			expected_results.push_back(r);
			clear_frame_state();
		end
	endtask

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, got %h", $time, got);
		end else begin
			want = expected_results.pop_front();
			report_field("result_kind", want.result_kind, got.result_kind);
			report_field("payload_byte", want.payload_byte, got.payload_byte);
			report_field("payload_index", want.payload_index, got.payload_index);
			report_field("status_code", want.status_code, got.status_code);
			report_field("frame_length", want.frame_length, got.frame_length);
			report_field("protocol_version", want.protocol_version, got.protocol_version);
			report_field("packet_type", want.packet_type, got.packet_type);
			report_field("command_code", want.command_code, got.command_code);
			report_field("payload_length", want.payload_length, got.payload_length);
			report_field("received_check", want.received_check, got.received_check);
			report_field("last", want.last, got.last);
			if (got.result_kind == KIND_STATUS) begin
				statuses_seen++;
				if (got.status_code <= ST_BAD_CRC) begin
					status_hist[got.status_code]++;
				end
			end else begin
				payloads_seen++;
			end
		end
	endtask

	// Both channels are sampled at the rising edge, before any of this edge's
	// nonblocking updates land. A byte's results pass the input register and the result
	// queue before they can come out, so checking before predicting within one edge is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result(out_data);
			end
			if (in_valid && !in_stall) begin
				parse_byte(in_data, row_check);
			end
		end
	end

	// Receiver back-pressure. A new pattern is picked whenever the tick wraps: no stalls,
	// light or heavy random stalls, or a stall while the low four tick bits are under five.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0) begin
			stall_mode <= $urandom_range(0, 3);
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_tick[3:0] < 4'd5);
		endcase
	end

	// Sender: bytes go out in bursts of random length with random gaps in between.
	// Valid stays high from one transfer to the next inside a burst, and the payload
	// is only changed right after a transfer.
	task automatic send_byte(logic [7:0] b, logic eob, logic [3:0] tag);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		in_data <= in_item_t'{rx_byte: b, end_of_buffer: eob};
		row_check <= tag;
		do @(posedge clk); while (in_stall);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_buffer();
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
		for (int i = 0; i < buffer_bytes.size(); i++) begin
			send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1, FROM_MODEL);
		end
	endtask

	// Stops sending and waits for every queued result, then lets the pipeline settle so
	// that a register write cannot overlap a byte still in flight.
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (expected_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEADER_PATTERN: cfg_hp = val;
			REG_HEADER_LENGTH: cfg_hl = val[2:0];
			REG_MAX_FRAME_LENGTH: cfg_mfl = val[15:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Register settings of the random phases. Header lengths cover zero, the legal range
	// and the values that saturate; frame limits cover zero, exactly base, tight and full.
	task automatic apply_setting(int ph);
		logic [31:0] hp;
		logic [2:0] hl;
		logic [15:0] mfl;
		hp = $urandom;
		case (ph)
			0: begin hp = 32'hFFFF_FFFF; hl = 3'd4; mfl = 16'hFFFF; end
			1: begin hl = 3'd1; mfl = 16'd30; end
			2: begin hl = 3'd0; mfl = 16'd0; end
			3: begin hl = 3'd7; mfl = 16'd40; end
			4: begin hp = 32'h0; hl = 3'd3; mfl = 16'd13; end
			5: begin hl = 3'd5; mfl = 16'd200; end
			default: begin hl = 3'd2; mfl = HDLEN_RESET; end
		endcase
		write_reg(REG_HEADER_PATTERN, hp);
		write_reg(REG_HEADER_LENGTH, {29'd0, hl});
		write_reg(REG_MAX_FRAME_LENGTH, {16'd0, mfl});
	endtask

	// Builds one buffer under the current configuration. About half are clean frames
	// (some with trailing bytes); the rest carry one defect: a flipped header bit, a bad
	// or oversized length, a corrupted check value, a cut-off end, or plain noise.
	task automatic make_buffer(logic clean);
		int h;
		int base;
		int dlen;
		int pay_n;
		int sel;
		int n;
		logic [15:0] len_f;
		logic [15:0] crc;
		buffer_bytes.delete();
		h = header_bytes();
		base = h + BASE_EXTRA;
		sel = clean ? 0 : $urandom_range(0, 9);
		if (sel == 9) begin
			n = $urandom_range(1, 24);
			repeat (n) buffer_bytes.push_back(8'($urandom));
			return;
		end
		dlen = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		if (cfg_mfl >= base && base + dlen > cfg_mfl) begin
			dlen = cfg_mfl - base;
		end
		len_f = 16'(base + dlen);
		pay_n = dlen;
		if (sel == 6) begin
			if ($urandom_range(0, 1) == 1) begin
				len_f = len_f ^ (16'd1 << $urandom_range(0, 15));
			end else begin
				dlen = cfg_mfl - base + 1 + $urandom_range(0, 3);
				if (dlen < 0) begin
					dlen = 0;
				end
				len_f = 16'(base + dlen);
				pay_n = (dlen > 4) ? 4 : dlen;
			end
		end
		for (int i = 0; i < h; i++) begin
			buffer_bytes.push_back(cfg_hp[8*i +: 8]);
		end
		if (sel == 5 && h > 0) begin
			n = $urandom_range(0, h - 1);
			buffer_bytes[n] = buffer_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
		end
		buffer_bytes.push_back(len_f[15:8]);
		buffer_bytes.push_back(len_f[7:0]);
		buffer_bytes.push_back(8'($urandom));
		buffer_bytes.push_back(8'($urandom));
		buffer_bytes.push_back(8'($urandom));
		buffer_bytes.push_back(8'($urandom));
		buffer_bytes.push_back(8'(dlen >> 8));
		buffer_bytes.push_back(8'(dlen));
		repeat (pay_n) buffer_bytes.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (buffer_bytes[i]) begin
			crc = crc_step(crc, buffer_bytes[i]);
		end
		buffer_bytes.push_back(crc[15:8]);
		buffer_bytes.push_back(crc[7:0]);
		if (sel == 7) begin
			n = buffer_bytes.size() - 1 - $urandom_range(0, 1);
			buffer_bytes[n] = buffer_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
		end
		if (sel == 8) begin
			n = $urandom_range(1, buffer_bytes.size() - 1);
			while (buffer_bytes.size() > n) begin
				void'(buffer_bytes.pop_back());
			end
		end
		if (sel < 5 && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin
		int phase_start;
		logic [7:0] b;
		logic [15:0] table_crc;
		table_crc = CRC_INIT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset configuration.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			case (DIRECTED[i].kind)
				ROW_CRC_HI: b = table_crc[15:8];
				ROW_CRC_LO: b = table_crc[7:0];
				default: begin
					b = DIRECTED[i].value;
					table_crc = crc_step(table_crc, b);
				end
			endcase
			send_byte(b, DIRECTED[i].eob, DIRECTED[i].tag);
			if (DIRECTED[i].eob) begin
				table_crc = CRC_INIT;
			end
		end
		drain();

		// Random phases, one register setting each.
		for (int ph = 0; ph < PHASES; ph++) begin
			apply_setting(ph);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				make_buffer(1'b0);
				send_buffer();
			end
			drain();
		end

		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results expected but never transferred", $time,
				expected_results.size());
		end
		$display("Sent %0d bytes over %0d register settings; checked %0d payload bytes.",
			bytes_sent, PHASES + 1, payloads_seen);
		$display({"Status results: %0d ok, %0d too short, %0d bad header, ",
			"%0d bad length, %0d bad crc."},
			status_hist[0], status_hist[1], status_hist[2], status_hist[3], status_hist[4]);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dfr_pkg.sv
rtl/dfr_parse.sv
rtl/dfr_out_fifo.sv
rtl/frame_deframer_crc16_check_core.sv
rtl/dfr_checker.sv
tb/tb_frame_deframer_crc16_check_core.sv
